// ===== design/brld_pkg.sv =====
// Shared types and constants of the byte-run line decoder.
// Used by brld_ctrl, brld_dpath and the top level; depends on nothing.
package brld_pkg;

  localparam logic [1:0] CFG_LINE_MODE   = 2'd0;
  localparam logic [1:0] CFG_ROW_BYTES   = 2'd1;
  localparam logic [1:0] CFG_PLANE_COUNT = 2'd2;

  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [7:0] NOP_HEADER = 8'd128;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;

  typedef struct packed {
    logic take;
    logic emit;
  } brld_cmd_t;

  typedef struct packed {
    logic has_result;
    logic starts_repeat;
    logic last_pair;
  } brld_sts_t;

endpackage

// ===== design/byterun_line_decoder.sv =====
// Top level of the byte-run line decoder: PackBits or pass-through lines.
// Instantiates brld_ctrl and brld_dpath; uses brld_pkg.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o     stream_byte_i
//   out       output     out_valid_o / out_ready_i   first_byte_o .. status_o
//   cfg       input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// Header, literal and pass-through bytes are taken straight from the input.
// A repeat byte is emitted by the single result register, one pair per cycle
// unless stalled; input is held off meanwhile. A full result register with
// out_ready_i low stalls the input.
// Reset restores line mode 1, two-byte rows and one plane.
module byterun_line_decoder #(
  parameter int unsigned MAX_ROW_BYTES = 256,
  parameter int unsigned MAX_PLANES    = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [brld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     stream_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     first_byte_o,
  output logic [7:0]                     second_byte_o,
  output logic [1:0]                     byte_count_o,
  output logic                           line_done_o,
  output logic                           last_of_run_o,
  output logic                           status_o
);

  brld_pkg::brld_cmd_t cmd;
  brld_pkg::brld_sts_t sts;

  brld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brld_dpath #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_PLANES    (MAX_PLANES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .stream_byte_i (stream_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .byte_count_o  (byte_count_o),
    .line_done_o   (line_done_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status_o)
  );

endmodule

// ===== design/brld_ctrl.sv =====
// Controller of the byte-run line decoder: handshakes and repeat sequencing.
// Depends on brld_pkg; drives brld_dpath through command and status structs.
module brld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  brld_pkg::brld_sts_t sts_i,
  output brld_pkg::brld_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.take = (state_q == ST_IDLE) && in_valid_i && slot_free;
    cmd_o.emit = (state_q == ST_EMIT) && slot_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.take && sts_i.starts_repeat) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit && sts_i.last_pair) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if ((cmd_o.take && sts_i.has_result) || cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/brld_dpath.sv =====
// Datapath of the byte-run line decoder: configuration, row and line
// counters, decode phase, run counters and the result register. Uses brld_pkg.
module brld_dpath #(
  parameter int unsigned MAX_ROW_BYTES = 256,
  parameter int unsigned MAX_PLANES    = 9
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [brld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [7:0]                          stream_byte_i,
  input  brld_pkg::brld_cmd_t                 cmd_i,
  output brld_pkg::brld_sts_t                 sts_o,
  output logic [7:0]                          first_byte_o,
  output logic [7:0]                          second_byte_o,
  output logic [1:0]                          byte_count_o,
  output logic                                line_done_o,
  output logic                                last_of_run_o,
  output logic                                status_o
);

  localparam int unsigned RW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned PW  = $clog2(MAX_PLANES + 1);
  localparam int unsigned CW  = (RW > 9) ? RW : 9;
  localparam int unsigned PCW = (PW > 4) ? PW : 4;
  localparam int unsigned KW  = 1 + PW + RW;

  logic          mode_q, mode_d;
  logic [8:0]    row_q, row_d;
  logic [3:0]    planes_q, planes_d;
  logic [RW-1:0] eff_row;
  logic [PW-1:0] eff_planes;

  logic [RW-1:0] left_q, left_d;
  logic [PW-1:0] rows_q, rows_d;
  logic [1:0]    phase_q, phase_d;
  logic [7:0]    lit_q, lit_d;
  logic [7:0]    rep_q, rep_d;
  logic [7:0]    rep_byte_q, rep_byte_d;

  logic [7:0] first_q, first_d, second_q, second_d;
  logic [1:0] count_q, count_d;
  logic       done_q, done_d, last_q, last_d, stat_q, stat_d;

  logic          restart;
  logic [8:0]    run_len;
  logic          overrun;
  logic [KW-1:0] step1, step2;
  logic [7:0]    lit_dec, rep_rem;
  logic          pair;

  function automatic logic [KW-1:0] consume(input logic [RW-1:0] left,
                                            input logic [PW-1:0] rows,
                                            input logic [RW-1:0] er,
                                            input logic [PW-1:0] ep);
    logic [RW-1:0] l1;
    logic [PW-1:0] r1;
    l1 = (left != '0) ? left - RW'(1) : left;
    r1 = (rows != '0) ? rows - PW'(1) : rows;
    if (l1 != '0) begin
      consume = {1'b0, rows, l1};
    end else if (r1 == '0) begin
      consume = {1'b1, ep, er};
    end else begin
      consume = {1'b0, r1, er};
    end
  endfunction

  always_comb begin
    mode_d   = mode_q;
    row_d    = row_q;
    planes_d = planes_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brld_pkg::CFG_LINE_MODE: begin
          mode_d  = cfg_data_i[0];
          restart = 1'b1;
        end
        brld_pkg::CFG_ROW_BYTES: begin
          row_d   = cfg_data_i;
          restart = 1'b1;
        end
        brld_pkg::CFG_PLANE_COUNT: begin
          planes_d = cfg_data_i[3:0];
          restart  = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (row_d == 9'd0) begin
      eff_row = RW'(1);
    end else if (CW'(row_d) > CW'(MAX_ROW_BYTES)) begin
      eff_row = RW'(MAX_ROW_BYTES);
    end else begin
      eff_row = RW'(row_d);
    end
    if (planes_d == 4'd0) begin
      eff_planes = PW'(1);
    end else if (PCW'(planes_d) > PCW'(MAX_PLANES)) begin
      eff_planes = PW'(MAX_PLANES);
    end else begin
      eff_planes = PW'(planes_d);
    end
  end

  assign run_len = (stream_byte_i < brld_pkg::NOP_HEADER) ?
                   {1'b0, stream_byte_i} + 9'd1 : 9'd257 - {1'b0, stream_byte_i};
  assign overrun = CW'(run_len) > CW'(left_q);
  assign pair    = rep_q >= 8'd2;
  assign rep_rem = pair ? rep_q - 8'd2 : rep_q - 8'd1;
  assign lit_dec = (lit_q != 8'd0) ? lit_q - 8'd1 : lit_q;
  assign step1   = consume(left_q, rows_q, eff_row, eff_planes);
  assign step2   = consume(step1[RW-1:0], step1[RW+PW-1:RW], eff_row, eff_planes);

  always_comb begin
    sts_o.has_result = !mode_q || (phase_q == brld_pkg::PH_LITERAL) ||
                       ((phase_q == brld_pkg::PH_HEADER) &&
                        (stream_byte_i != brld_pkg::NOP_HEADER) && overrun);
    sts_o.starts_repeat = mode_q && (phase_q == brld_pkg::PH_REPEAT);
    sts_o.last_pair     = rep_q <= 8'd2;
  end

  always_comb begin
    left_d     = left_q;
    rows_d     = rows_q;
    phase_d    = phase_q;
    lit_d      = lit_q;
    rep_d      = rep_q;
    rep_byte_d = rep_byte_q;
    first_d    = first_q;
    second_d   = second_q;
    count_d    = count_q;
    done_d     = done_q;
    last_d     = last_q;
    stat_d     = stat_q;
    if (restart) begin
      left_d  = eff_row;
      rows_d  = eff_planes;
      phase_d = brld_pkg::PH_HEADER;
      lit_d   = 8'd0;
      rep_d   = 8'd0;
    end else if (cmd_i.take) begin
      if (!mode_q || phase_q == brld_pkg::PH_LITERAL) begin
        left_d   = step1[RW-1:0];
        rows_d   = step1[RW+PW-1:RW];
        first_d  = stream_byte_i;
        second_d = 8'd0;
        count_d  = 2'd1;
        done_d   = step1[KW-1];
        last_d   = 1'b1;
        stat_d   = 1'b0;
        if (mode_q) begin
          lit_d = lit_dec;
          if (lit_dec == 8'd0) phase_d = brld_pkg::PH_HEADER;
        end
      end else if (phase_q == brld_pkg::PH_REPEAT) begin
        rep_byte_d = stream_byte_i;
      end else if (stream_byte_i != brld_pkg::NOP_HEADER) begin
        if (overrun) begin
          left_d   = eff_row;
          rows_d   = eff_planes;
          phase_d  = brld_pkg::PH_HEADER;
          lit_d    = 8'd0;
          rep_d    = 8'd0;
          first_d  = 8'd0;
          second_d = 8'd0;
          count_d  = 2'd0;
          done_d   = 1'b1;
          last_d   = 1'b1;
          stat_d   = 1'b1;
        end else if (stream_byte_i < brld_pkg::NOP_HEADER) begin
          lit_d   = run_len[7:0];
          phase_d = brld_pkg::PH_LITERAL;
        end else begin
          rep_d   = run_len[7:0];
          phase_d = brld_pkg::PH_REPEAT;
        end
      end
    end else if (cmd_i.emit) begin
      first_d  = rep_byte_q;
      second_d = pair ? rep_byte_q : 8'd0;
      count_d  = pair ? 2'd2 : 2'd1;
      if (pair) begin
        left_d = step2[RW-1:0];
        rows_d = step2[RW+PW-1:RW];
        done_d = step2[KW-1];
      end else begin
        left_d = step1[RW-1:0];
        rows_d = step1[RW+PW-1:RW];
        done_d = step1[KW-1];
      end
      last_d = rep_rem == 8'd0;
      stat_d = 1'b0;
      rep_d  = rep_rem;
      if (rep_rem == 8'd0) phase_d = brld_pkg::PH_HEADER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b1;
      row_q    <= 9'd2;
      planes_q <= 4'd1;
      left_q   <= RW'(2);
      rows_q   <= PW'(1);
      phase_q  <= brld_pkg::PH_HEADER;
      lit_q    <= 8'd0;
      rep_q    <= 8'd0;
    end else begin
      mode_q   <= mode_d;
      row_q    <= row_d;
      planes_q <= planes_d;
      left_q   <= left_d;
      rows_q   <= rows_d;
      phase_q  <= phase_d;
      lit_q    <= lit_d;
      rep_q    <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_byte_q <= rep_byte_d;
    first_q    <= first_d;
    second_q   <= second_d;
    count_q    <= count_d;
    done_q     <= done_d;
    last_q     <= last_d;
    stat_q     <= stat_d;
  end

  assign first_byte_o  = first_q;
  assign second_byte_o = second_q;
  assign byte_count_o  = count_q;
  assign line_done_o   = done_q;
  assign last_of_run_o = last_q;
  assign status_o      = stat_q;

endmodule

// ===== design/brld_checker.sv =====
// Port-level checks of the byte-run line decoder, bound to the top level.
// Depends on byterun_line_decoder only through its ports.
module brld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] first_byte_o,
  input logic [1:0] byte_count_o,
  input logic       line_done_o,
  input logic       last_of_run_o,
  input logic       status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_byte_o))
    else $error("result dropped or changed while stalled");

  a_ready_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input taken while result register is blocked");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |->
      byte_count_o == 2'd0 && line_done_o && last_of_run_o)
    else $error("overrun result malformed");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == 2'd0 |-> status_o)
    else $error("empty result without overrun");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o != 2'd3)
    else $error("byte count out of range");

endmodule

bind byterun_line_decoder brld_checker u_brld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .first_byte_o  (first_byte_o),
  .byte_count_o  (byte_count_o),
  .line_done_o   (line_done_o),
  .last_of_run_o (last_of_run_o),
  .status_o      (status_o)
);
